// ----- src/ccbs_pkg.sv -----
package ccbs_pkg;

    localparam int unsigned TIME_WIDTH_DEF = 32;
    localparam int unsigned NOW_W          = 32;
    localparam int unsigned TMO_W          = 16;
    localparam int unsigned REC_W          = 4;
    localparam int unsigned CFG_IDX_W      = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_TMO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TMO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_WAIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FATAL_HOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECOV  = 3'd4;

    localparam logic [TMO_W-1:0] DETECT_TMO_RST = 16'd2000;
    localparam logic [TMO_W-1:0] LOCK_TMO_RST   = 16'd2000;
    localparam logic [TMO_W-1:0] RETRY_WAIT_RST = 16'd1000;
    localparam logic [TMO_W-1:0] FATAL_HOLD_RST = 16'd2000;
    localparam logic [REC_W-1:0] MAX_RECOV_RST  = 4'd3;

    // reported sequencer state codes
    localparam logic [2:0] SEQ_INIT     = 3'd0;
    localparam logic [2:0] SEQ_RESET    = 3'd1;
    localparam logic [2:0] SEQ_SYSCLK   = 3'd2;
    localparam logic [2:0] SEQ_WAITLOCK = 3'd3;
    localparam logic [2:0] SEQ_SETUP    = 3'd4;
    localparam logic [2:0] SEQ_RUN      = 3'd5;
    localparam logic [2:0] SEQ_ERROR    = 3'd6;
    localparam logic [2:0] SEQ_FATAL    = 3'd7;

    // error causes
    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_PIN_TEST = 3'd1;
    localparam logic [2:0] CAUSE_NOTFOUND = 3'd2;
    localparam logic [2:0] CAUSE_LOCK_TMO = 3'd3;
    localparam logic [2:0] CAUSE_UNLOCKED = 3'd4;
    localparam logic [2:0] CAUSE_FATAL    = 3'd5;

    // device presence
    localparam logic [1:0] PRES_ABSENT = 2'd0;
    localparam logic [1:0] PRES_NORMAL = 2'd1;
    localparam logic [1:0] PRES_FAILED = 2'd2;

    typedef struct packed {
        logic [TMO_W-1:0] detect_timeout_ms;
        logic [TMO_W-1:0] lock_timeout_ms;
        logic [TMO_W-1:0] retry_wait_ms;
        logic [TMO_W-1:0] fatal_hold_ms;
        logic [REC_W-1:0] max_recoveries;
    } t_cfg;

    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic             run_enable;
        logic             power_enable;
        logic             pin_test_ok;
        logic             device_found;
        logic             soft_reset_ok;
        logic             sysclk_config_ok;
        logic             lock_seen;
        logic             stable_seen;
        logic             setup_ok;
        logic             sysclk_read_ok;
        logic             status_read_ok;
    } t_poll;

    typedef struct packed {
        logic [2:0]       seq_state;
        logic [REC_W-1:0] retry_count;
        logic [1:0]       presence;
        logic [2:0]       error_cause;
        logic             entered_error;
        logic             entered_run;
        logic             reset_requested;
    } t_result;

endpackage

// ----- src/clock_chip_bringup_sequencer.sv -----
// Bring-up and supervision sequencer for an external clock synthesiser. Each
// poll transaction carries a millisecond timestamp, the enables and the
// pass/fail flags of the helper operations of one run-loop pass; the block
// answers each with one result transaction (state, retry count, presence,
// error cause and entry pulses). One poll is taken every clock cycle while
// o_in_stall is low; a poll lands in the input register, and the state
// update in ccbs_fsm then loads its result into the result register once
// that register is free. Every pass reads back the state that ccbs_fsm
// registered on the pass before.
// Timeouts count from the last state change, modulo 2^TIME_WIDTH. The
// configuration port is always ready; write it only while no poll is in
// flight. Input stall rises only when the input register is full and the
// result register is held by a downstream stall.
module clock_chip_bringup_sequencer
    import ccbs_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // poll channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [NOW_W-1:0]     i_now_ms,
    input  logic                 i_run_enable,
    input  logic                 i_power_enable,
    input  logic                 i_pin_test_ok,
    input  logic                 i_device_found,
    input  logic                 i_soft_reset_ok,
    input  logic                 i_sysclk_config_ok,
    input  logic                 i_lock_seen,
    input  logic                 i_stable_seen,
    input  logic                 i_setup_ok,
    input  logic                 i_sysclk_read_ok,
    input  logic                 i_status_read_ok,

    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_seq_state,
    output logic [REC_W-1:0]     o_retry_count,
    output logic [1:0]           o_presence,
    output logic [2:0]           o_error_cause,
    output logic                 o_entered_error,
    output logic                 o_entered_run,
    output logic                 o_reset_requested,

    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TMO_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_poll   poll_in;
    t_result res;

    logic    r_in_valid;
    t_poll   r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    out_free;   // result register empty or being drained
    logic    fire;       // input register holds a poll and the result slot is free
    logic    in_take;

    assign o_cfg_ready = 1'b1;

    ccbs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    always_comb begin
        poll_in.now_ms           = i_now_ms;
        poll_in.run_enable       = i_run_enable;
        poll_in.power_enable     = i_power_enable;
        poll_in.pin_test_ok      = i_pin_test_ok;
        poll_in.device_found     = i_device_found;
        poll_in.soft_reset_ok    = i_soft_reset_ok;
        poll_in.sysclk_config_ok = i_sysclk_config_ok;
        poll_in.lock_seen        = i_lock_seen;
        poll_in.stable_seen      = i_stable_seen;
        poll_in.setup_ok         = i_setup_ok;
        poll_in.sysclk_read_ok   = i_sysclk_read_ok;
        poll_in.status_read_ok   = i_status_read_ok;
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= poll_in;
        end
    end

    ccbs_fsm #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_poll  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_seq_state       = r_out.seq_state;
    assign o_retry_count     = r_out.retry_count;
    assign o_presence        = r_out.presence;
    assign o_error_cause     = r_out.error_cause;
    assign o_entered_error   = r_out.entered_error;
    assign o_entered_run     = r_out.entered_run;
    assign o_reset_requested = r_out.reset_requested;

endmodule

// ----- src/ccbs_cfg_regs.sv -----
module ccbs_cfg_regs
    import ccbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [TMO_W-1:0]     i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_timeout_ms <= DETECT_TMO_RST;
            r_cfg.lock_timeout_ms   <= LOCK_TMO_RST;
            r_cfg.retry_wait_ms     <= RETRY_WAIT_RST;
            r_cfg.fatal_hold_ms     <= FATAL_HOLD_RST;
            r_cfg.max_recoveries    <= MAX_RECOV_RST;
        end else if (i_wr) begin
            unique case (i_idx)
                CFG_DETECT_TMO: r_cfg.detect_timeout_ms <= i_data;
                CFG_LOCK_TMO:   r_cfg.lock_timeout_ms   <= i_data;
                CFG_RETRY_WAIT: r_cfg.retry_wait_ms     <= i_data;
                CFG_FATAL_HOLD: r_cfg.fatal_hold_ms     <= i_data;
                CFG_MAX_RECOV:  r_cfg.max_recoveries    <= i_data[REC_W-1:0];
                default: ; // unmapped index, ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/ccbs_fsm.sv -----
module ccbs_fsm
    import ccbs_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_poll   i_poll,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    typedef enum logic [2:0] {
        ST_INIT     = SEQ_INIT,
        ST_RESET    = SEQ_RESET,
        ST_SYSCLK   = SEQ_SYSCLK,
        ST_WAITLOCK = SEQ_WAITLOCK,
        ST_SETUP    = SEQ_SETUP,
        ST_RUN      = SEQ_RUN,
        ST_ERROR    = SEQ_ERROR,
        ST_FATAL    = SEQ_FATAL
    } t_state;

    localparam logic [REC_W-1:0] REC_SAT = '1;

    t_state                r_state,  n_state;
    logic [TIME_WIDTH-1:0] r_start;
    logic [REC_W-1:0]      r_rec,    n_rec;
    logic                  r_locked, n_locked;
    logic                  r_stable, n_stable;
    logic [1:0]            r_pres,   n_pres;

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [2:0]            cause;
    logic                  rst_req;
    logic                  changed;

    assign now_t   = TIME_WIDTH'(i_poll.now_ms);
    assign elapsed = now_t - r_start;

    always_comb begin
        n_state  = r_state;
        n_rec    = r_rec;
        n_locked = r_locked;
        n_stable = r_stable;
        n_pres   = r_pres;
        cause    = CAUSE_NONE;
        rst_req  = 1'b0;

        unique case (r_state)
            ST_INIT: begin
                if (i_poll.run_enable && i_poll.power_enable) begin
                    if (i_poll.pin_test_ok) begin
                        n_state = ST_RESET;
                    end else begin
                        n_state = ST_ERROR;
                        cause   = CAUSE_PIN_TEST;
                    end
                end
            end
            ST_RESET: begin
                rst_req = 1'b1;
                n_pres  = i_poll.device_found ? PRES_NORMAL : PRES_ABSENT;
                if (i_poll.device_found) begin
                    n_state = i_poll.soft_reset_ok ? ST_SYSCLK : ST_ERROR;
                end else if (elapsed > TIME_WIDTH'(i_cfg.detect_timeout_ms)) begin
                    n_state = ST_ERROR;
                    cause   = CAUSE_NOTFOUND;
                end
            end
            ST_SYSCLK: begin
                n_state = i_poll.sysclk_config_ok ? ST_WAITLOCK : ST_ERROR;
            end
            ST_WAITLOCK: begin
                // timeout wins over lock seen in the same pass
                if (elapsed > TIME_WIDTH'(i_cfg.lock_timeout_ms)) begin
                    n_state = ST_ERROR;
                    cause   = CAUSE_LOCK_TMO;
                end else if (r_locked && r_stable) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = i_poll.setup_ok ? ST_RUN : ST_ERROR;
            end
            ST_RUN: begin
                if (!r_locked) begin
                    n_state = ST_ERROR;
                    cause   = CAUSE_UNLOCKED;
                end else begin
                    n_rec = '0;
                end
            end
            ST_ERROR: begin
                if (r_rec > i_cfg.max_recoveries) begin
                    n_state = ST_FATAL;
                    cause   = CAUSE_FATAL;
                end else if (elapsed > TIME_WIDTH'(i_cfg.retry_wait_ms)) begin
                    if (r_rec != REC_SAT) begin
                        n_rec = r_rec + 1'b1;
                    end
                    n_state = ST_INIT;
                end
            end
            ST_FATAL: begin
                n_pres = PRES_FAILED;
                if (elapsed > TIME_WIDTH'(i_cfg.fatal_hold_ms)) begin
                    n_rec   = '0;
                    n_state = ST_INIT;
                end
            end
            default: ;
        endcase

        // end-of-pass status reads in the active clock states
        if (n_state == ST_SYSCLK || n_state == ST_WAITLOCK ||
            n_state == ST_SETUP || n_state == ST_RUN) begin
            if (i_poll.sysclk_read_ok) begin
                n_locked = i_poll.lock_seen;
                n_stable = i_poll.stable_seen;
            end else begin
                n_state = ST_ERROR;
            end
        end
        if (n_state == ST_RUN && !i_poll.status_read_ok) begin
            n_state = ST_ERROR;
        end
    end

    assign changed = (n_state != r_state);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_start  <= '0;
            r_rec    <= '0;
            r_locked <= 1'b0;
            r_stable <= 1'b0;
            r_pres   <= PRES_ABSENT;
        end else if (i_fire) begin
            r_state  <= n_state;
            r_rec    <= n_rec;
            r_locked <= n_locked;
            r_stable <= n_stable;
            r_pres   <= n_pres;
            if (changed) begin
                r_start <= now_t;
            end
        end
    end

    always_comb begin
        o_res.seq_state       = n_state;
        o_res.retry_count     = n_rec;
        o_res.presence        = n_pres;
        o_res.error_cause     = cause;
        o_res.entered_error   = changed && (r_state != ST_RESET) && (n_state == ST_ERROR);
        o_res.entered_run     = changed && (r_state != ST_RESET) && (n_state == ST_RUN);
        o_res.reset_requested = rst_req;
    end

endmodule

// ----- src/ccbs_checker.sv -----
module ccbs_checker
    import ccbs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [2:0]       o_seq_state,
    input logic [REC_W-1:0] o_retry_count,
    input logic [2:0]       o_error_cause,
    input logic             o_entered_error,
    input logic             o_entered_run
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_seq_state) &&
        $stable(o_retry_count) && $stable(o_error_cause))
        else $error("result changed while stalled");

    a_run_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_entered_run |-> o_seq_state == SEQ_RUN)
        else $error("entered_run without run state");

    a_err_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_entered_error |-> o_seq_state == SEQ_ERROR)
        else $error("entered_error without error state");

    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_cause != CAUSE_NONE |->
        (o_seq_state == SEQ_ERROR && o_error_cause != CAUSE_FATAL) ||
        (o_seq_state == SEQ_FATAL && o_error_cause == CAUSE_FATAL))
        else $error("error cause inconsistent with state");

endmodule

bind clock_chip_bringup_sequencer ccbs_checker u_ccbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_seq_state     (o_seq_state),
    .o_retry_count   (o_retry_count),
    .o_error_cause   (o_error_cause),
    .o_entered_error (o_entered_error),
    .o_entered_run   (o_entered_run)
);

// ----- tb/sv/tb.sv -----
module tb;
    import ccbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Poll flag masks, in t_poll bit order below the timestamp (run_enable is the MSB).
    localparam logic [10:0] F_NONE  = 11'h000;
    localparam logic [10:0] F_RUN   = 11'h400;
    localparam logic [10:0] F_PWR   = 11'h200;
    localparam logic [10:0] F_PIN   = 11'h100;
    localparam logic [10:0] F_FOUND = 11'h080;
    localparam logic [10:0] F_SRST  = 11'h040;
    localparam logic [10:0] F_SYS   = 11'h020;
    localparam logic [10:0] F_LOCK  = 11'h010;
    localparam logic [10:0] F_STAB  = 11'h008;
    localparam logic [10:0] F_SETUP = 11'h004;
    localparam logic [10:0] F_SYSRD = 11'h002;
    localparam logic [10:0] F_STRD  = 11'h001;

    // Index with no register behind it: the write must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam int N_SCRIPT        = 27;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int HOLD_CYCLES     = 150;
    localparam int REPORT_LIMIT    = 10;

    localparam t_result NO_REPORT = '0;

    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic [10:0]      flags;
        logic             known;   // want holds a hand-worked report
        t_result          want;
    } t_script_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [NOW_W-1:0]     i_now_ms;
    logic                 i_run_enable;
    logic                 i_power_enable;
    logic                 i_pin_test_ok;
    logic                 i_device_found;
    logic                 i_soft_reset_ok;
    logic                 i_sysclk_config_ok;
    logic                 i_lock_seen;
    logic                 i_stable_seen;
    logic                 i_setup_ok;
    logic                 i_sysclk_read_ok;
    logic                 i_status_read_ok;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [2:0]           o_seq_state;
    logic [REC_W-1:0]     o_retry_count;
    logic [1:0]           o_presence;
    logic [2:0]           o_error_cause;
    logic                 o_entered_error;
    logic                 o_entered_run;
    logic                 o_reset_requested;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TMO_W-1:0]     i_cfg_data;

    clock_chip_bringup_sequencer dut (.*);

    // Shadow copy of the sequencer, advanced once per accepted poll transaction.
    t_cfg             seq_cfg    = '{DETECT_TMO_RST, LOCK_TMO_RST, RETRY_WAIT_RST,
                                     FATAL_HOLD_RST, MAX_RECOV_RST};
    logic [2:0]       seq_state  = SEQ_INIT;
    logic [NOW_W-1:0] seq_since  = '0;
    logic [REC_W-1:0] seq_recov  = '0;
    logic             seq_locked = 1'b0;
    logic             seq_stable = 1'b0;
    logic [1:0]       seq_pres   = PRES_ABSENT;

    t_result pending_reports [$];
    int      fail_count = 0;
    int      calm_left  = 0;     // sender: polls still to go with no gap
    int      hold_len   = 0;     // receiver: one-off long hold-off request
    logic [NOW_W-1:0] wall_ms;

    // Hand-walked bring-up. Runs with max_recoveries = 1 and reset timeouts.
    // Covers pin test failure, retry wait boundary, detect timeout boundary, fatal
    // entry and hold, timestamp wrap during reset, the full path into run,
    // loss of lock in run, and a lock timeout beating lock in the same pass.
    t_script_row bringup_script [N_SCRIPT] = '{
        '{32'd0,     F_NONE,         1'b1,
          '{SEQ_INIT,  4'd0, PRES_ABSENT, CAUSE_NONE,     1'b0, 1'b0, 1'b0}},
        '{32'd5,     F_RUN | F_PWR,  1'b1,
          '{SEQ_ERROR, 4'd0, PRES_ABSENT, CAUSE_PIN_TEST, 1'b1, 1'b0, 1'b0}},
        '{32'd1005,  F_NONE,         1'b1,
          '{SEQ_ERROR, 4'd0, PRES_ABSENT, CAUSE_NONE,     1'b0, 1'b0, 1'b0}},
        '{32'd1006,  F_NONE,         1'b1,
          '{SEQ_INIT,  4'd1, PRES_ABSENT, CAUSE_NONE,     1'b0, 1'b0, 1'b0}},
        '{32'd1007,  F_RUN,                   1'b0, NO_REPORT},
        '{32'd1008,  F_RUN | F_PWR | F_PIN,   1'b0, NO_REPORT},
        '{32'd3008,  F_RUN | F_PWR,           1'b0, NO_REPORT},
        '{32'd3009,  F_NONE,         1'b1,
          '{SEQ_ERROR, 4'd1, PRES_ABSENT, CAUSE_NOTFOUND, 1'b0, 1'b0, 1'b1}},
        '{32'd4010,  F_NONE,                  1'b0, NO_REPORT},
        '{32'd4011,  F_RUN | F_PWR,           1'b0, NO_REPORT},
        '{32'd4012,  F_NONE,         1'b1,
          '{SEQ_FATAL, 4'd2, PRES_ABSENT, CAUSE_FATAL,    1'b0, 1'b0, 1'b0}},
        '{32'd6012,  F_NONE,         1'b1,
          '{SEQ_FATAL, 4'd2, PRES_FAILED, CAUSE_NONE,     1'b0, 1'b0, 1'b0}},
        '{32'd6013,  F_NONE,         1'b1,
          '{SEQ_INIT,  4'd0, PRES_FAILED, CAUSE_NONE,     1'b0, 1'b0, 1'b0}},
        '{32'hFFFF_FFF0, F_RUN | F_PWR | F_PIN,         1'b0, NO_REPORT},
        '{32'h0000_0010, F_FOUND | F_SRST | F_SYSRD,    1'b0, NO_REPORT},
        '{32'h0000_0011, F_SYS | F_SYSRD | F_LOCK,      1'b0, NO_REPORT},
        '{32'h0000_0012, F_SYSRD | F_LOCK | F_STAB,     1'b0, NO_REPORT},
        '{32'h0000_0013, F_SYSRD | F_LOCK | F_STAB,     1'b0, NO_REPORT},
        '{32'h0000_0014, F_SETUP | F_SYSRD | F_STRD | F_LOCK, 1'b0, NO_REPORT},
        '{32'h0000_0015, F_SYSRD | F_STRD | F_LOCK,     1'b0, NO_REPORT},
        '{32'h0000_0016, F_SYSRD | F_STRD,              1'b0, NO_REPORT},
        '{32'h0000_0017, F_SYSRD | F_STRD,              1'b0, NO_REPORT},
        '{32'h0000_0400, F_NONE,                        1'b0, NO_REPORT},
        '{32'h0000_0401, F_RUN | F_PWR | F_PIN,         1'b0, NO_REPORT},
        '{32'h0000_0402, F_FOUND | F_SRST | F_SYSRD | F_LOCK | F_STAB, 1'b0, NO_REPORT},
        '{32'h0000_0403, F_SYS | F_SYSRD | F_LOCK | F_STAB,            1'b0, NO_REPORT},
        '{32'd3028,  F_SYSRD | F_LOCK | F_STAB, 1'b1,
          '{SEQ_ERROR, 4'd1, PRES_NORMAL, CAUSE_LOCK_TMO, 1'b1, 1'b0, 1'b0}}
    };

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // One run-loop pass of the sequencer: updates the shadow state and returns
    // the report the block should give for this poll.
    function automatic t_result step_sequencer(input t_poll p);
        logic [NOW_W-1:0] elapsed;
        logic [2:0]       nxt;
        logic [2:0]       cause;
        logic             probing;
        logic             changed;
        t_result          r;
        elapsed = p.now_ms - seq_since;   // wraps modulo 2^32
        nxt     = seq_state;
        cause   = CAUSE_NONE;
        probing = 1'b0;
        case (seq_state)
            SEQ_INIT: begin
                if (p.run_enable && p.power_enable) begin
                    if (p.pin_test_ok) begin
                        nxt = SEQ_RESET;
                    end else begin
                        nxt   = SEQ_ERROR;
                        cause = CAUSE_PIN_TEST;
                    end
                end
            end
            SEQ_RESET: begin
                probing  = 1'b1;
                seq_pres = p.device_found ? PRES_NORMAL : PRES_ABSENT;
                if (p.device_found) begin
                    nxt = p.soft_reset_ok ? SEQ_SYSCLK : SEQ_ERROR;
                end else if (elapsed > seq_cfg.detect_timeout_ms) begin
                    nxt   = SEQ_ERROR;
                    cause = CAUSE_NOTFOUND;
                end
            end
            SEQ_SYSCLK: nxt = p.sysclk_config_ok ? SEQ_WAITLOCK : SEQ_ERROR;
            SEQ_WAITLOCK: begin
                // latches come from the previous pass; the timeout has the last word
                if (seq_locked && seq_stable) nxt = SEQ_SETUP;
                if (elapsed > seq_cfg.lock_timeout_ms) begin
                    nxt   = SEQ_ERROR;
                    cause = CAUSE_LOCK_TMO;
                end
            end
            SEQ_SETUP: nxt = p.setup_ok ? SEQ_RUN : SEQ_ERROR;
            SEQ_RUN: begin
                if (!seq_locked) begin
                    nxt   = SEQ_ERROR;
                    cause = CAUSE_UNLOCKED;
                end else begin
                    seq_recov = '0;
                end
            end
            SEQ_ERROR: begin
                if (seq_recov > seq_cfg.max_recoveries) begin
                    nxt   = SEQ_FATAL;
                    cause = CAUSE_FATAL;
                end else if (elapsed > seq_cfg.retry_wait_ms) begin
                    if (seq_recov != '1) seq_recov = seq_recov + 1'b1;
                    nxt = SEQ_INIT;
                end
            end
            default: begin
                seq_pres = PRES_FAILED;
                if (elapsed > seq_cfg.fatal_hold_ms) begin
                    seq_recov = '0;
                    nxt       = SEQ_INIT;
                end
            end
        endcase
        // status read at the end of the pass, only once past detection
        if (nxt inside {SEQ_SYSCLK, SEQ_WAITLOCK, SEQ_SETUP, SEQ_RUN}) begin
            if (p.sysclk_read_ok) begin
                seq_locked = p.lock_seen;
                seq_stable = p.stable_seen;
            end else begin
                nxt = SEQ_ERROR;
            end
        end
        if (nxt == SEQ_RUN && !p.status_read_ok) nxt = SEQ_ERROR;
        changed = (nxt != seq_state);
        r.seq_state       = nxt;
        r.retry_count     = seq_recov;
        r.presence        = seq_pres;
        r.error_cause     = cause;
        r.entered_error   = changed && seq_state != SEQ_RESET && nxt == SEQ_ERROR;
        r.entered_run     = changed && seq_state != SEQ_RESET && nxt == SEQ_RUN;
        r.reset_requested = probing;
        if (changed) seq_since = p.now_ms;
        seq_state = nxt;
        return r;
    endfunction

    function automatic logic likely(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Sender gap: mostly 0..7, with occasional back-to-back stretches.
    function automatic int next_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // Mostly plausible passes (helpers usually succeed, time creeps forward) so
    // that the walk regularly gets through to run; one in ten is pure noise.
    function automatic t_poll random_poll();
        t_poll p;
        int    roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)      wall_ms += $urandom_range(0, 2);
        else if (roll < 95) wall_ms += $urandom_range(0, 60);
        else if (roll < 99) wall_ms += $urandom_range(0, 70000);
        else                wall_ms = $urandom;
        p.now_ms = wall_ms;
        if ($urandom_range(0, 9) == 0) begin
            p[10:0] = 11'($urandom);
        end else begin
            p.run_enable       = likely(95);
            p.power_enable     = likely(95);
            p.pin_test_ok      = likely(90);
            p.device_found     = likely(85);
            p.soft_reset_ok    = likely(92);
            p.sysclk_config_ok = likely(92);
            p.lock_seen        = likely(88);
            p.stable_seen      = likely(88);
            p.setup_ok         = likely(92);
            p.sysclk_read_ok   = likely(92);
            p.status_read_ok   = likely(92);
        end
        return p;
    endfunction

    function automatic t_cfg phase_settings(input int ph);
        t_cfg c;
        c.detect_timeout_ms = 16'($urandom_range(0, 40));
        c.lock_timeout_ms   = 16'($urandom_range(0, 40));
        c.retry_wait_ms     = 16'($urandom_range(0, 40));
        c.fatal_hold_ms     = 16'($urandom_range(0, 40));
        c.max_recoveries    = 4'($urandom_range(0, 4));
        case (ph)
            0: c = '0;
            1: c = '1;
            4: c.max_recoveries = 4'd14;
            5: c.max_recoveries = 4'd15;   // never fatal, so retries saturate
            default: ;
        endcase
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TMO_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        case (idx)
            CFG_DETECT_TMO: seq_cfg.detect_timeout_ms = data;
            CFG_LOCK_TMO:   seq_cfg.lock_timeout_ms   = data;
            CFG_RETRY_WAIT: seq_cfg.retry_wait_ms     = data;
            CFG_FATAL_HOLD: seq_cfg.fatal_hold_ms     = data;
            CFG_MAX_RECOV:  seq_cfg.max_recoveries    = data[REC_W-1:0];
            default: ;
        endcase
    endtask

    // Back-to-back writes keep valid high throughout; it drops once at the end.
    task automatic configure(input t_cfg c, input logic with_spare);
        logic [TMO_W-1:0] recov_word;
        // junk in the upper bits must be dropped by the 4-bit register
        recov_word = {(TMO_W - REC_W)'($urandom), c.max_recoveries};
        write_reg(CFG_DETECT_TMO, c.detect_timeout_ms);
        write_reg(CFG_LOCK_TMO,   c.lock_timeout_ms);
        write_reg(CFG_RETRY_WAIT, c.retry_wait_ms);
        write_reg(CFG_FATAL_HOLD, c.fatal_hold_ms);
        write_reg(CFG_MAX_RECOV,  recov_word);
        if (with_spare) write_reg(CFG_SPARE, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Offers one poll transaction; valid stays high afterwards so a following
    // poll with no gap goes straight out.
    task automatic offer_poll(input t_poll p, input logic known, input t_result want);
        int      gap;
        t_result pred;
        gap = next_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_now_ms           <= p.now_ms;
        i_run_enable       <= p.run_enable;
        i_power_enable     <= p.power_enable;
        i_pin_test_ok      <= p.pin_test_ok;
        i_device_found     <= p.device_found;
        i_soft_reset_ok    <= p.soft_reset_ok;
        i_sysclk_config_ok <= p.sysclk_config_ok;
        i_lock_seen        <= p.lock_seen;
        i_stable_seen      <= p.stable_seen;
        i_setup_ok         <= p.setup_ok;
        i_sysclk_read_ok   <= p.sysclk_read_ok;
        i_status_read_ok   <= p.status_read_ok;
        i_in_valid         <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        pred = step_sequencer(p);
        pending_reports.push_back(known ? want : pred);
    endtask

    task automatic wait_reports_drained();
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_report(input t_result got);
        t_result want;
        if (pending_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: report with none pending (state %0d)", $time, got.seq_state);
            return;
        end
        want = pending_reports.pop_front();
        if (got.seq_state       !== want.seq_state   ||
            got.retry_count     !== want.retry_count ||
            got.presence        !== want.presence    ||
            got.error_cause     !== want.error_cause ||
            got.entered_error   !== want.entered_error ||
            got.entered_run     !== want.entered_run ||
            got.reset_requested !== want.reset_requested) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display({"%0t: mismatch exp/act state %0d/%0d retry %0d/%0d pres %0d/%0d ",
                          "cause %0d/%0d err %0b/%0b run %0b/%0b rst %0b/%0b"}, $time,
                         want.seq_state, got.seq_state, want.retry_count, got.retry_count,
                         want.presence, got.presence, want.error_cause, got.error_cause,
                         want.entered_error, got.entered_error, want.entered_run,
                         got.entered_run, want.reset_requested, got.reset_requested);
        end
    endtask

    // Result side: a random per-report stall, quiet stretches, and the
    // odd long hold-off so the block backs up into the poll channel.
    initial begin : report_sink
        t_result got;
        int      n;
        int      quiet_left;
        quiet_left  = 0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                n        = hold_len;
                hold_len = 0;
            end else if (quiet_left > 0) begin
                n = 0;
                quiet_left--;
            end else if ($urandom_range(0, 39) == 0) begin
                n          = 0;
                quiet_left = $urandom_range(20, 60);
            end else begin
                n = $urandom_range(0, 7);
            end
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            got = {o_seq_state, o_retry_count, o_presence, o_error_cause,
                   o_entered_error, o_entered_run, o_reset_requested};
            check_report(got);
        end
    end

    initial begin : stimulus
        t_cfg  c;
        t_poll p;
        int    ph;
        int    k;
        i_rst_n            <= 1'b0;
        i_in_valid         <= 1'b0;
        i_now_ms           <= '0;
        i_run_enable       <= 1'b0;
        i_power_enable     <= 1'b0;
        i_pin_test_ok      <= 1'b0;
        i_device_found     <= 1'b0;
        i_soft_reset_ok    <= 1'b0;
        i_sysclk_config_ok <= 1'b0;
        i_lock_seen        <= 1'b0;
        i_stable_seen      <= 1'b0;
        i_setup_ok         <= 1'b0;
        i_sysclk_read_ok   <= 1'b0;
        i_status_read_ok   <= 1'b0;
        i_cfg_valid        <= 1'b0;
        i_cfg_index        <= '0;
        i_cfg_data         <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // scripted bring-up: reset timeouts, two retries allowed before fatal
        c = seq_cfg;
        c.max_recoveries = 4'd1;
        configure(c, 1'b0);
        for (k = 0; k < N_SCRIPT; k++) begin
            p = {bringup_script[k].now_ms, bringup_script[k].flags};
            offer_poll(p, bringup_script[k].known, bringup_script[k].want);
        end
        wall_ms = bringup_script[N_SCRIPT-1].now_ms;

        // random phases; the block is drained before each reconfiguration
        for (ph = 0; ph < N_PHASES; ph++) begin
            i_in_valid <= 1'b0;
            wait_reports_drained();
            configure(phase_settings(ph), ph == 3);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ((ph == 2 || ph == 4) && k == 50) begin
                    hold_len  = HOLD_CYCLES;
                    calm_left = 40;
                end
                offer_poll(random_poll(), 1'b0, NO_REPORT);
            end
        end
        i_in_valid <= 1'b0;
        wait_reports_drained();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #2ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ccbs_pkg.sv
src/ccbs_cfg_regs.sv
src/ccbs_fsm.sv
src/clock_chip_bringup_sequencer.sv
src/ccbs_checker.sv
tb/sv/tb.sv
